FILE: hw/rtl/can_signal_mapper_core_assert.svh
// Assertion macros for the CAN signal mapper core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CAN_SIGNAL_MAPPER_CORE_ASSERT_SVH
`define CAN_SIGNAL_MAPPER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/csm_pkg.sv
// Shared types and constants of the CAN signal mapper.
// No dependencies.
`default_nettype none
package csm_pkg;
   localparam int MapEntries = 32;
   localparam int InputSlots = 256;
   localparam int ValueWidth = 32;
   localparam int TimeWidth  = 32;
   localparam int EntryIdxW  = $clog2(MapEntries);
   localparam int EntryCntW  = $clog2(MapEntries + 1);
   localparam int SlotW      = 8;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD, S_RD0, S_RD1, S_SCAN_RD, S_SCAN_EV, S_SCAN_WR, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic add_write;  // write new entry + default into slot
      logic rd_slot;    // queried-slot read state (slot RAM read is ungated)
      logic rd_fin;     // capture read result
      logic scan_rd;    // entry table read state at scan index (read is ungated)
      logic scan_ev;    // evaluate entry
      logic scan_wr;    // write slot/stamp if needed
      logic scan_clr;   // reset scan index
      logic tick_inc;   // advance time
   } cmd_ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    scan_last;
   } dp_stat_type;
endpackage
`default_nettype wire

FILE: hw/rtl/csm_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module csm_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/csm_datapath.sv
// Datapath: entry table, slot store, time counter and result register.
// Depends on csm_pkg and csm_ram.
`default_nettype none
module csm_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire csm_pkg::cmd_ctl_type ctl,
   output csm_pkg::dp_stat_type      stat,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [28:0]          req_msg_id,
   input  wire logic [63:0]          req_frame_data,
   input  wire logic [5:0]           req_bit_pos,
   input  wire logic [5:0]           req_bit_len,
   input  wire logic [7:0]           req_slot,
   input  wire logic [7:0]           req_default_value,
   input  wire logic [15:0]          req_timeout_ticks,
   output logic [1:0]                res_status,
   output logic [csm_pkg::ValueWidth-1:0] res_value
);
   localparam int IW = csm_pkg::EntryIdxW;
   localparam int CW = csm_pkg::EntryCntW;
   localparam int VW = csm_pkg::ValueWidth;
   localparam int TW = csm_pkg::TimeWidth;
   // entry record: id, pos, len, slot, default, timeout
   localparam int EW = 29 + 6 + 6 + 8 + 8 + 16;

   // captured request
   csm_pkg::cmd_type cmd_ff;
   logic [28:0] id_ff;
   logic [63:0] data_ff;
   logic [5:0]  pos_ff, len_ff;
   logic [7:0]  slot_ff, dflt_ff;
   logic [15:0] tmo_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] now_ff, now_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [csm_pkg::InputSlots-1:0] present_ff, present_in;
   logic [1:0]    status_ff, status_in;
   logic [VW-1:0] value_ff, value_in;

   // evaluated scan step
   logic          hit_ff;
   logic [VW-1:0] wval_ff;
   logic [7:0]    wslot_ff;

   logic [5:0] len_clamp;
   assign len_clamp = (req_bit_len > 6'd32) ? 6'd32 : req_bit_len;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= csm_pkg::cmd_type'(req_cmd);
         id_ff   <= req_msg_id;
         data_ff <= req_frame_data;
         pos_ff  <= req_bit_pos;
         len_ff  <= len_clamp;
         slot_ff <= req_slot;
         dflt_ff <= req_default_value;
         tmo_ff  <= req_timeout_ticks;
      end
   end

   // entry table and stamp memory
   logic          ent_we, stamp_we;
   logic [IW-1:0] ent_wa, stamp_wa;
   logic [EW-1:0] ent_wd, ent_rd;
   logic [TW-1:0] stamp_wd, stamp_rd;

   assign ent_we = ctl.add_write && !stat.full;
   assign ent_wa = count_ff[IW-1:0];
   assign ent_wd = {id_ff, pos_ff, len_ff, slot_ff, dflt_ff, tmo_ff};
   assign stamp_we = ent_we || (ctl.scan_wr && hit_ff && cmd_ff == csm_pkg::CMD_FRAME);
   assign stamp_wa = ent_we ? ent_wa : idx_ff;
   assign stamp_wd = now_ff;

   csm_ram #(.Width(EW), .Depth(csm_pkg::MapEntries)) u_ent (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(idx_ff), .rd_data(ent_rd));
   csm_ram #(.Width(TW), .Depth(csm_pkg::MapEntries)) u_stamp (
      .clock(clock), .wr_en(stamp_we), .wr_addr(stamp_wa), .wr_data(stamp_wd),
      .rd_addr(idx_ff), .rd_data(stamp_rd));

   // slot value memory
   logic          slot_we;
   logic [7:0]    slot_wa;
   logic [VW-1:0] slot_wd, slot_rd;
   always_comb begin
      slot_we = 1'b0;
      slot_wa = slot_ff;
      slot_wd = VW'(dflt_ff);
      if (ent_we) begin
         slot_we = 1'b1;
      end else if (ctl.scan_wr && hit_ff) begin
         slot_we = 1'b1;
         slot_wa = wslot_ff;
         slot_wd = wval_ff;
      end
   end
   csm_ram #(.Width(VW), .Depth(csm_pkg::InputSlots)) u_slot (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ff), .rd_data(slot_rd));

   // evaluate one entry
   logic [28:0] e_id;
   logic [5:0]  e_pos, e_len;
   logic [7:0]  e_slot, e_dflt;
   logic [15:0] e_tmo;
   logic [63:0] shifted, fmask;
   logic [TW-1:0] elapsed;
   assign {e_id, e_pos, e_len, e_slot, e_dflt, e_tmo} = ent_rd;
   assign shifted = data_ff >> e_pos;
   assign fmask   = (e_len == 6'd0) ? 64'd0 : ((64'd1 << e_len) - 64'd1);
   assign elapsed = now_ff - stamp_rd;

   always_ff @(posedge clock) begin
      if (ctl.scan_ev) begin
         wslot_ff <= e_slot;
         if (cmd_ff == csm_pkg::CMD_FRAME) begin
            hit_ff  <= (e_id == id_ff);
            wval_ff <= VW'(shifted & fmask);
         end else begin
            hit_ff  <= (elapsed > TW'(e_tmo));
            wval_ff <= VW'(e_dflt);
         end
      end
   end

   // control registers
   always_comb begin
      count_in   = count_ff;
      now_in     = now_ff;
      idx_in     = idx_ff;
      present_in = present_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      if (ctl.load) begin
         status_in = csm_pkg::ST_OK;
         value_in  = '0;
      end
      if (ctl.add_write) begin
         if (stat.full) begin
            status_in = csm_pkg::ST_FULL;
         end else begin
            count_in = count_ff + CW'(1);
            present_in[slot_ff] = 1'b1;
         end
      end
      if (ctl.scan_wr && hit_ff) begin
         present_in[wslot_ff] = 1'b1;
      end
      if (ctl.tick_inc) begin
         now_in = now_ff + TW'(1);
      end
      if (ctl.scan_clr) begin
         idx_in = '0;
      end else if (ctl.scan_wr) begin
         idx_in = idx_ff + IW'(1);
      end
      if (ctl.rd_fin) begin
         if (present_ff[slot_ff]) begin
            value_in = slot_rd;
         end else begin
            status_in = csm_pkg::ST_NOTFOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         now_ff     <= '0;
         idx_ff     <= '0;
         present_ff <= '0;
         status_ff  <= '0;
         value_ff   <= '0;
      end else begin
         count_ff   <= count_in;
         now_ff     <= now_in;
         idx_ff     <= idx_in;
         present_ff <= present_in;
         status_ff  <= status_in;
         value_ff   <= value_in;
      end
   end

   assign stat.cmd       = cmd_ff;
   assign stat.full      = (count_ff == CW'(csm_pkg::MapEntries));
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_last = (CW'(idx_ff) + CW'(1) >= count_ff) || (count_ff == '0);
   assign res_status = status_ff;
   assign res_value  = value_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/csm_ctrl.sv
// Controller state machine sequencing add, frame/tick scans and reads.
// Depends on csm_pkg.
`default_nettype none
module csm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic                 rsp_fire,
   input  wire csm_pkg::dp_stat_type stat,
   input  wire logic                 empty,
   output csm_pkg::cmd_ctl_type      ctl,
   output logic                      busy,
   output logic                      done
);
   csm_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csm_pkg::S_IDLE: begin
            if (req_fire) state_in = csm_pkg::S_ADD;
         end
         csm_pkg::S_ADD: begin
            case (stat.cmd)
               csm_pkg::CMD_ADD:  state_in = csm_pkg::S_DONE;
               csm_pkg::CMD_READ: state_in = csm_pkg::S_RD0;
               default:           state_in = empty ? csm_pkg::S_DONE : csm_pkg::S_SCAN_RD;
            endcase
         end
         csm_pkg::S_RD0:     state_in = csm_pkg::S_RD1;
         csm_pkg::S_RD1:     state_in = csm_pkg::S_DONE;
         csm_pkg::S_SCAN_RD: state_in = csm_pkg::S_SCAN_EV;
         csm_pkg::S_SCAN_EV: state_in = csm_pkg::S_SCAN_WR;
         csm_pkg::S_SCAN_WR: state_in = stat.scan_last ? csm_pkg::S_DONE
                                                      : csm_pkg::S_SCAN_RD;
         csm_pkg::S_DONE: begin
            if (rsp_fire) state_in = csm_pkg::S_IDLE;
         end
         default: state_in = csm_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      case (state_ff)
         csm_pkg::S_IDLE: begin
            ctl.load     = req_fire;
            ctl.scan_clr = 1'b1;
         end
         csm_pkg::S_ADD: begin
            ctl.add_write = (stat.cmd == csm_pkg::CMD_ADD);
            ctl.tick_inc  = (stat.cmd == csm_pkg::CMD_TICK);
         end
         csm_pkg::S_RD0:     ctl.rd_slot = 1'b1;
         csm_pkg::S_RD1:     ctl.rd_fin  = 1'b1;
         csm_pkg::S_SCAN_RD: ctl.scan_rd = 1'b1;
         csm_pkg::S_SCAN_EV: ctl.scan_ev = 1'b1;
         csm_pkg::S_SCAN_WR: ctl.scan_wr = 1'b1;
         default: ;
      endcase
   end

   assign busy = (state_ff != csm_pkg::S_IDLE);
   assign done = (state_ff == csm_pkg::S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/can_signal_mapper_core.sv
// CAN signal mapper core: entry table, timeouts, slot store.
// Frame and tick commands scan every stored entry after the command state.
// One item in flight: next request taken the cycle after the result transfer.
// The scan sequencer visits table entries one at a time through a registered RAM.
// Synchronous active-high reset clears table count, slot present bits, time.
`default_nettype none
`include "can_signal_mapper_core_assert.svh"
module can_signal_mapper_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: command[1:0], msg_id[30:2], frame_data[94:31], bit_pos[100:95],
   // bit_len[106:101], slot[114:107], default_value[122:115],
   // timeout_ticks[138:123], zero fill to 144
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: status[1:0], read_value[33:2], zero fill to 40
   output logic [39:0]       rsp_tdata
);
   csm_pkg::cmd_ctl_type ctl;
   csm_pkg::dp_stat_type stat;
   logic busy, done, req_fire, rsp_fire, empty;
   logic [1:0]  res_status;
   logic [31:0] res_value;
   logic [143:0] unused_fill;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = !busy;
   assign rsp_tvalid = done;
   assign empty = stat.empty;
   assign unused_fill = req_tdata;

   csm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .stat(stat), .empty(empty), .ctl(ctl), .busy(busy), .done(done));

   csm_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat),
      .req_cmd(req_tdata[1:0]), .req_msg_id(req_tdata[30:2]),
      .req_frame_data(req_tdata[94:31]), .req_bit_pos(req_tdata[100:95]),
      .req_bit_len(req_tdata[106:101]), .req_slot(req_tdata[114:107]),
      .req_default_value(req_tdata[122:115]),
      .req_timeout_ticks(req_tdata[138:123]),
      .res_status(res_status), .res_value(res_value));

   assign rsp_tdata = {6'd0, res_value, res_status};

   `CSM_ASSERT_IMPL(a_no_accept_busy, clock, reset, busy, !req_tready, "ready while busy")
   `CSM_ASSERT_NEXT(a_rsp_after_fire, clock, reset, rsp_fire, !rsp_tvalid, "response repeated")
   `CSM_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, res_status != 2'd3, "bad status")
endmodule
`default_nettype wire

FILE: tb/can_signal_mapper_core_chk.sv
// Checker for the CAN signal mapper core: watches both stream channels,
// predicts each response from its own copy of the table and slots, compares.
// Depends on csm_pkg.
`default_nettype none
module can_signal_mapper_core_chk
   import csm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [143:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [39:0]  rsp_tdata,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
   } rsp_type;

   // mirror of the mapping table and slot store
   logic [28:0] map_id[MapEntries];
   logic [5:0]  map_pos[MapEntries];
   logic [5:0]  map_len[MapEntries];
   logic [7:0]  map_slot[MapEntries];
   logic [7:0]  map_dflt[MapEntries];
   logic [15:0] map_tmo[MapEntries];
   logic [31:0] map_stamp[MapEntries];
   int          map_count;
   logic [31:0] slot_val[InputSlots];
   logic        slot_set[InputSlots];
   logic [31:0] now_ticks;
   rsp_type     expected_rsp[$];

   // apply one request to the mirror and return its response
   function automatic rsp_type mapper_step(logic [143:0] d);
      cmd_type     cmd;
      logic [28:0] id;
      logic [63:0] data;
      logic [5:0]  len;
      logic [7:0]  slot;
      logic [63:0] field;
      rsp_type     r;
      cmd = cmd_type'(d[1:0]);
      id = d[30:2];
      data = d[94:31];
      len = (d[106:101] > 6'd32) ? 6'd32 : d[106:101];
      slot = d[114:107];
      r.status = ST_OK;
      r.value = '0;
      case (cmd)
         CMD_ADD: begin
            if (map_count >= MapEntries) begin
               r.status = ST_FULL;
            end else begin
               map_id[map_count] = id;
               map_pos[map_count] = d[100:95];
               map_len[map_count] = len;
               map_slot[map_count] = slot;
               map_dflt[map_count] = d[122:115];
               map_tmo[map_count] = d[138:123];
               map_stamp[map_count] = now_ticks;
               map_count++;
               slot_val[slot] = {24'd0, d[122:115]};
               slot_set[slot] = 1'b1;
            end
         end
         CMD_FRAME: begin
            // matches in table order, last one wins
            for (int i = 0; i < map_count; i++) begin
               if (map_id[i] == id) begin
                  field = data >> map_pos[i];
                  field &= (64'd1 << map_len[i]) - 64'd1;
                  slot_val[map_slot[i]] = field[31:0];
                  slot_set[map_slot[i]] = 1'b1;
                  map_stamp[i] = now_ticks;
               end
            end
         end
         CMD_TICK: begin
            now_ticks = now_ticks + 32'd1;
            for (int i = 0; i < map_count; i++) begin
               if (now_ticks - map_stamp[i] > {16'd0, map_tmo[i]}) begin
                  slot_val[map_slot[i]] = {24'd0, map_dflt[i]};
                  slot_set[map_slot[i]] = 1'b1;
               end
            end
         end
         default: begin
            if (slot_set[slot]) r.value = slot_val[slot];
            else r.status = ST_NOTFOUND;
         end
      endcase
      return r;
   endfunction

   initial begin
      fail_count = 0;
      map_count = 0;
      now_ticks = '0;
      foreach (slot_set[i]) slot_set[i] = 1'b0;
   end

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         // predict on each accepted request
         if (req_tvalid && req_tready)
            expected_rsp.insert(expected_rsp.size(), mapper_step(req_tdata));
         // compare each response transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.value = rsp_tdata[33:2];
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response status=%0d value=%h",
                           $realtime, got.status, got.value);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status != want.status || got.value != want.value
                   || rsp_tdata[39:34] != '0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch status exp=%0d got=%0d value exp=%h got=%h",
                              $realtime, want.status, got.status, want.value, got.value);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/can_signal_mapper_core_tb.sv
// Testbench top for the CAN signal mapper core: clock, reset, request
// stimulus and response backpressure. Depends on csm_pkg and the checker.
`default_nettype none
module can_signal_mapper_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csm_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;
   int           fail_count;
   int           pending;
   logic         calm;

   logic [28:0]  id_pool[8];
   logic [7:0]   added_slots[$];
   logic [28:0]  added_ids[$];

   can_signal_mapper_core uut (.*);

   can_signal_mapper_core_chk chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // response side backpressure
   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 32);

   // one request transfer, sometimes with a random gap ahead of it
   task automatic send(cmd_type cmd, logic [28:0] id, logic [63:0] data, logic [5:0] pos,
                       logic [5:0] len, logic [7:0] slot, logic [7:0] dflt,
                       logic [15:0] tmo);
      if (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, tmo, dflt, slot, len, pos, data, id, cmd};
      if (cmd == CMD_ADD) begin
         added_ids.insert(added_ids.size(), id);
         added_slots.insert(added_slots.size(), slot);
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_item();
      int          pick;
      logic [28:0] id;
      logic [7:0]  slot;
      logic [15:0] tmo;
      pick = $urandom_range(99);
      id = ($urandom_range(9) < 2) ? 29'($urandom) : id_pool[$urandom_range(7)];
      slot = (added_slots.size() > 0 && $urandom_range(9) < 7)
             ? added_slots[$urandom_range(added_slots.size() - 1)] : 8'($urandom);
      tmo = ($urandom_range(9) < 6) ? 16'($urandom_range(8)) : 16'($urandom);
      if (pick < ((added_ids.size() < MapEntries) ? 12 : 3)) begin
         send(CMD_ADD, id, '0, 6'($urandom), 6'($urandom), ($urandom_range(3) == 0)
              ? 8'($urandom) : 8'($urandom_range(15)), 8'($urandom), tmo);
      end else if (pick < 45) begin
         if (added_ids.size() > 0 && $urandom_range(9) < 8)
            id = added_ids[$urandom_range(added_ids.size() - 1)];
         send(CMD_FRAME, id, {$urandom, $urandom}, 6'($urandom), 6'($urandom),
              8'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 72) begin
         send(CMD_TICK, 29'($urandom), {$urandom, $urandom}, 6'($urandom), 6'($urandom),
              8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
         send(CMD_READ, 29'($urandom), {$urandom, $urandom}, 6'($urandom), 6'($urandom),
              slot, 8'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 8; i++) id_pool[i] = 29'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme adds, overlapping matches, timeouts
      send(CMD_READ, '0, '0, '0, '0, 8'd0, '0, '0);
      send(CMD_FRAME, '0, '1, '0, '0, '0, '0, '0);
      send(CMD_TICK, '0, '0, '0, '0, '0, '0, '0);
      send(CMD_ADD, '0, '0, 6'd0, 6'd0, 8'd0, 8'd0, 16'd0);
      send(CMD_ADD, '1, '0, 6'd63, 6'd63, 8'd255, 8'd255, 16'hFFFF);
      send(CMD_ADD, 29'h123, '0, 6'd4, 6'd32, 8'd10, 8'hAA, 16'd2);
      send(CMD_ADD, 29'h123, '0, 6'd8, 6'd8, 8'd10, 8'h55, 16'd3);
      send(CMD_ADD, 29'h123, '0, 6'd60, 6'd33, 8'd11, 8'h01, 16'd1);
      send(CMD_READ, '0, '0, '0, '0, 8'd0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd255, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd10, '0, '0);
      send(CMD_FRAME, 29'h123, '1, '0, '0, '0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd10, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd11, '0, '0);
      send(CMD_FRAME, '1, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd255, '0, '0);
      for (int i = 0; i < 4; i++) send(CMD_TICK, '0, '0, '0, '0, '0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd10, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd11, '0, '0);
      send(CMD_FRAME, '0, 64'h0123_4567_89AB_CDEF, '0, '0, '0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd0, '0, '0);
      send(CMD_READ, '0, '0, '0, '0, 8'd77, '0, '0);

      // hold off until every response is back
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // random traffic, with a stretch without idling
      for (int n = 0; n < 1800; n++) begin
         calm = (n >= 700 && n < 1000);
         random_item();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/csm_pkg.sv
hw/rtl/csm_ram.sv
hw/rtl/csm_datapath.sv
hw/rtl/csm_ctrl.sv
hw/rtl/can_signal_mapper_core.sv
tb/can_signal_mapper_core_chk.sv
tb/can_signal_mapper_core_tb.sv
